### rtl/rmst_pkg.sv
// Shared types and constants for the range-minimum segment tree unit.
// Holds field widths, stream word layout, controller states and the command/status structs.
// No dependencies.
package rmst_pkg;

	localparam int CNT_W  = 11;
	localparam int IDX_W  = 10;
	localparam int DATA_W = 32;

	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 32;

	localparam int INDEX_LSB = 0;
	localparam int VALUE_LSB = INDEX_LSB + IDX_W;
	localparam int RLOW_LSB  = VALUE_LSB + DATA_W;
	localparam int RHIGH_LSB = RLOW_LSB + IDX_W;

	localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
	localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic REG_ELEMENT_COUNT = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_LD_DESC,
		ST_LD_RD,
		ST_LD_WR,
		ST_Q_WALK,
		ST_Q_DRAIN,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic capture;
		logic init;
		logic ld_step;
		logic ld_leaf;
		logic ld_rd;
		logic ld_wr;
		logic q_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic is_load;
		logic load_ok;
		logic q_empty;
		logic leaf;
		logic at_root;
		logic parent_root;
		logic q_last;
		logic out_free;
	} stat_t;

endpackage

### rtl/rmst_ctrl.sv
// Controller state machine for the range-minimum segment tree unit.
// Sequences loads (descend, then refresh up to the root) and queries (stack walk).
// Depends on rmst_pkg.
module rmst_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  rmst_pkg::stat_t   st,
	output rmst_pkg::cmd_t    cmd,
	output rmst_pkg::state_t  cur_state
);

	rmst_pkg::state_t state_q;
	rmst_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rmst_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			rmst_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = rmst_pkg::ST_DECODE;
				end
			end
			rmst_pkg::ST_DECODE: begin
				if (st.is_load) begin
					if (st.load_ok) begin
						cmd.init = 1'b1;
						state_d  = rmst_pkg::ST_LD_DESC;
					end else begin
						state_d = rmst_pkg::ST_IDLE;
					end
				end else begin
					cmd.init = 1'b1;
					state_d  = st.q_empty ? rmst_pkg::ST_FIN : rmst_pkg::ST_Q_WALK;
				end
			end
			rmst_pkg::ST_LD_DESC: begin
				if (st.leaf) begin
					cmd.ld_leaf = 1'b1;
					state_d     = st.at_root ? rmst_pkg::ST_IDLE : rmst_pkg::ST_LD_RD;
				end else begin
					cmd.ld_step = 1'b1;
				end
			end
			rmst_pkg::ST_LD_RD: begin
				cmd.ld_rd = 1'b1;
				state_d   = rmst_pkg::ST_LD_WR;
			end
			rmst_pkg::ST_LD_WR: begin
				cmd.ld_wr = 1'b1;
				state_d   = st.parent_root ? rmst_pkg::ST_IDLE : rmst_pkg::ST_LD_RD;
			end
			rmst_pkg::ST_Q_WALK: begin
				cmd.q_step = 1'b1;
				if (st.q_last) begin
					state_d = rmst_pkg::ST_Q_DRAIN;
				end
			end
			rmst_pkg::ST_Q_DRAIN: begin
				state_d = rmst_pkg::ST_FIN;
			end
			rmst_pkg::ST_FIN: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = rmst_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rmst_pkg::ST_IDLE;
			end
		endcase
	end

	assign cur_state = state_q;

endmodule

### rtl/rmst_dpath.sv
// Datapath for the range-minimum segment tree unit: item registers, tree node walker,
// query stack, single-port tree memory, running minimum and output register.
// Depends on rmst_pkg.
module rmst_dpath #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [rmst_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  logic [0:0]                          s_tuser,
	input  logic [rmst_pkg::CNT_W-1:0]          n,
	input  rmst_pkg::cmd_t                      cmd,
	output rmst_pkg::stat_t                     st,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [rmst_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output logic [0:0]                          m_tuser
);

	localparam int CNT_W   = rmst_pkg::CNT_W;
	localparam int IDX_W   = rmst_pkg::IDX_W;
	localparam int DATA_W  = rmst_pkg::DATA_W;
	localparam int CAP     = (MAX_ELEMENTS > 2047) ? 2047 : MAX_ELEMENTS;
	localparam int DEPTH   = 4 * MAX_ELEMENTS;
	localparam int NODE_W  = $clog2(DEPTH);
	localparam int STK_D   = $clog2(CAP) + 2;
	localparam int STK_IW  = $clog2(STK_D);
	localparam int SP_W    = $clog2(STK_D + 1);

	logic                     op_q;
	logic [IDX_W-1:0]         idx_q;
	logic signed [DATA_W-1:0] val_q;
	logic [IDX_W-1:0]         rl_q;
	logic [IDX_W-1:0]         rh_q;
	logic [CNT_W-1:0]         rclip_q;
	logic [NODE_W-1:0]        node_q;
	logic [CNT_W-1:0]         lo_q;
	logic [CNT_W-1:0]         hi_q;
	logic signed [DATA_W-1:0] cur_q;
	logic signed [DATA_W-1:0] acc_q;
	logic                     empty_q;
	logic [SP_W-1:0]          sp_q;
	logic                     rd_pend_q;
	logic signed [DATA_W-1:0] rdata_q;
	logic                     mval_q;
	logic signed [DATA_W-1:0] mmin_q;
	logic                     memp_q;

	logic [NODE_W-1:0]        stk_node_q [STK_D];
	logic [CNT_W-1:0]         stk_lo_q   [STK_D];
	logic [CNT_W-1:0]         stk_hi_q   [STK_D];

	logic signed [DATA_W-1:0] mem [DEPTH];

	logic [CNT_W-1:0]         n_m1;
	logic [CNT_W-1:0]         idx_ext;
	logic [CNT_W-1:0]         rl_ext;
	logic [CNT_W-1:0]         rh_ext;
	logic [CNT_W:0]           span_sum;
	logic [CNT_W-1:0]         mid;
	logic [NODE_W-1:0]        child_l;
	logic [NODE_W-1:0]        child_r;
	logic [NODE_W-1:0]        node_m1;
	logic [NODE_W-1:0]        parent;
	logic [NODE_W-1:0]        sibling;
	logic                     disjoint;
	logic                     contained;
	logic                     stk_empty;
	logic [SP_W-1:0]          sp_m1;
	logic [STK_IW-1:0]        top_i;
	logic [STK_IW-1:0]        push_i;
	logic signed [DATA_W-1:0] new_min;
	logic signed [DATA_W-1:0] acc_min;
	logic                     mem_we;
	logic                     mem_re;
	logic [NODE_W-1:0]        mem_addr;
	logic signed [DATA_W-1:0] mem_wdata;

	assign n_m1      = n - CNT_W'(1);
	assign idx_ext   = CNT_W'(idx_q);
	assign rl_ext    = CNT_W'(rl_q);
	assign rh_ext    = CNT_W'(rh_q);
	assign span_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid       = span_sum[CNT_W:1];
	assign child_l   = NODE_W'({node_q, 1'b1});
	assign child_r   = child_l + NODE_W'(1);
	assign node_m1   = node_q - NODE_W'(1);
	assign parent    = {1'b0, node_m1[NODE_W-1:1]};
	assign sibling   = node_q[0] ? (node_q + NODE_W'(1)) : node_m1;
	assign disjoint  = (hi_q < rl_ext) || (lo_q > rclip_q);
	assign contained = (lo_q >= rl_ext) && (hi_q <= rclip_q);
	assign stk_empty = (sp_q == '0);
	assign sp_m1     = sp_q - SP_W'(1);
	assign top_i     = sp_m1[STK_IW-1:0];
	assign push_i    = sp_q[STK_IW-1:0];
	assign new_min   = (rdata_q < cur_q) ? rdata_q : cur_q;
	assign acc_min   = (rdata_q < acc_q) ? rdata_q : acc_q;

	assign st.is_load     = (op_q == rmst_pkg::OP_LOAD);
	assign st.load_ok     = (idx_ext < n);
	assign st.q_empty     = (n == '0) || (rl_q > rh_q) || (rl_ext >= n);
	assign st.leaf        = (lo_q == hi_q);
	assign st.at_root     = (node_q == '0);
	assign st.parent_root = (node_q == NODE_W'(1)) || (node_q == NODE_W'(2));
	assign st.q_last      = (disjoint || contained) && stk_empty;
	assign st.out_free    = !mval_q || m_tready;

	assign mem_we    = cmd.ld_leaf || cmd.ld_wr;
	assign mem_re    = cmd.ld_rd || (cmd.q_step && contained);
	assign mem_wdata = cmd.ld_wr ? new_min : val_q;

	always_comb begin
		if (cmd.ld_rd) begin
			mem_addr = sibling;
		end else if (cmd.ld_wr) begin
			mem_addr = parent;
		end else begin
			mem_addr = node_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end else if (mem_re) begin
			rdata_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= s_tuser[0];
			idx_q <= s_tdata[rmst_pkg::INDEX_LSB +: IDX_W];
			val_q <= s_tdata[rmst_pkg::VALUE_LSB +: DATA_W];
			rl_q  <= s_tdata[rmst_pkg::RLOW_LSB +: IDX_W];
			rh_q  <= s_tdata[rmst_pkg::RHIGH_LSB +: IDX_W];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			node_q  <= '0;
			lo_q    <= '0;
			hi_q    <= n_m1;
			rclip_q <= (rh_ext > n_m1) ? n_m1 : rh_ext;
			empty_q <= st.q_empty;
		end else if (cmd.ld_step) begin
			if (idx_ext <= mid) begin
				node_q <= child_l;
				hi_q   <= mid;
			end else begin
				node_q <= child_r;
				lo_q   <= mid + CNT_W'(1);
			end
		end else if (cmd.ld_wr) begin
			node_q <= parent;
		end else if (cmd.q_step) begin
			if (disjoint || contained) begin
				if (!stk_empty) begin
					node_q <= stk_node_q[top_i];
					lo_q   <= stk_lo_q[top_i];
					hi_q   <= stk_hi_q[top_i];
				end
			end else begin
				stk_node_q[push_i] <= child_r;
				stk_lo_q[push_i]   <= mid + CNT_W'(1);
				stk_hi_q[push_i]   <= hi_q;
				node_q             <= child_l;
				hi_q               <= mid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_leaf) begin
			cur_q <= val_q;
		end else if (cmd.ld_wr) begin
			cur_q <= new_min;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			acc_q <= rmst_pkg::INT_MAX;
		end else if (rd_pend_q) begin
			acc_q <= acc_min;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q      <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			rd_pend_q <= cmd.q_step && contained;
			if (cmd.init) begin
				sp_q <= '0;
			end else if (cmd.q_step) begin
				if (disjoint || contained) begin
					if (!stk_empty) begin
						sp_q <= sp_m1;
					end
				end else begin
					sp_q <= sp_q + SP_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mval_q <= 1'b0;
		end else if (cmd.out_load) begin
			mval_q <= 1'b1;
		end else if (m_tready) begin
			mval_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			mmin_q <= acc_q;
			memp_q <= empty_q;
		end
	end

	assign m_tvalid = mval_q;
	assign m_tdata  = mmin_q;
	assign m_tuser  = memp_q;

endmodule

### rtl/range_minimum_segment_tree_unit.sv
// Load: descend from the root to the leaf and write it, then refresh each parent up to the root
// (read the sibling, then write the minimum). Query: a stack walk over the tree nodes; empty ranges skip the walk.
// One word at a time: the next word is taken only once the last one is finished and the
// controller is back in idle, paced by the single port of the tree memory; a waiting result
// holds a query in its finish step until the output register frees.
// Reset clears the controller, stack pointer, output valid and element_count (to 1024).
// Tree memory has no reset; every element in use must be loaded before it is queried.
module range_minimum_segment_tree_unit #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// index[9:0], value[41:10], range_low[51:42], range_high[61:52], zero pad
	input  logic [rmst_pkg::IN_TDATA_W-1:0]  s_tdata,
	// op[0]
	input  logic [0:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// minimum[31:0]
	output logic [rmst_pkg::OUT_TDATA_W-1:0] m_tdata,
	// empty_res[0]
	output logic [0:0]                       m_tuser,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [2:0]                       paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	localparam int CNT_W = rmst_pkg::CNT_W;
	localparam int CAP   = (MAX_ELEMENTS > 2047) ? 2047 : MAX_ELEMENTS;

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  n;
	logic              cfg_wr;
	rmst_pkg::cmd_t    cmd;
	rmst_pkg::stat_t   st;
	rmst_pkg::state_t  cur_state;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == rmst_pkg::REG_ELEMENT_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= rmst_pkg::COUNT_RESET;
		end else if (cfg_wr) begin
			count_q <= pwdata[CNT_W-1:0];
		end
	end

	assign prdata = (paddr[2] == rmst_pkg::REG_ELEMENT_COUNT) ? {{(32-CNT_W){1'b0}}, count_q} : '0;
	assign n      = (count_q > CNT_W'(CAP)) ? CNT_W'(CAP) : count_q;

	rmst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.st        (st),
		.cmd       (cmd),
		.cur_state (cur_state)
	);

	rmst_dpath #(
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.n        (n),
		.cmd      (cmd),
		.st       (st),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	a_one_word_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a word is in progress");

	a_result_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cur_state == rmst_pkg::ST_FIN))
		else $error("result raised outside the finish step");

	a_empty_is_int_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata == rmst_pkg::INT_MAX))
		else $error("empty result without the maximum value");

endmodule

### tb/range_minimum_segment_tree_unit_tb.sv
// Self-checking bench for range_minimum_segment_tree_unit: stream loads and range queries,
// APB access to element_count, scoreboard with a flat-array minimum predictor.
// Depends on rmst_pkg and the unit itself.
module range_minimum_segment_tree_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_COUNT    = 1024;
	localparam int DRAIN_CYCLES = 64;
	localparam int MAX_IDLE     = 16;
	localparam int LONG_HOLD    = 600;
	localparam logic [2:0] COUNT_ADDR = {rmst_pkg::REG_ELEMENT_COUNT, 2'b00};
	localparam int PHASES = 8;
	localparam int COUNT_PLAN [PHASES] = '{2047, 1, 2, 0, 3, 5, 16, 40};

	typedef struct {
		logic signed [rmst_pkg::DATA_W-1:0] minimum;
		logic                               empty;
	} min_result_t;

	class range_min_board;
		logic signed [rmst_pkg::DATA_W-1:0] elems [MAX_COUNT];
		int unsigned                        count = MAX_COUNT;
		min_result_t                        pending_minima [$];
		int                                 errors = 0;

		function void set_count(logic [rmst_pkg::CNT_W-1:0] v);
			count = (v > MAX_COUNT) ? MAX_COUNT : v;
		endfunction

		function void note_word(logic op, logic [rmst_pkg::IDX_W-1:0] idx,
			logic signed [rmst_pkg::DATA_W-1:0] val,
			logic [rmst_pkg::IDX_W-1:0] lo, logic [rmst_pkg::IDX_W-1:0] hi);
			min_result_t r;
			int          top;
			if (op == rmst_pkg::OP_LOAD) begin
				if (idx < count)
					elems[idx] = val;
				return;
			end
			r.empty   = 1'b1;
			r.minimum = rmst_pkg::INT_MAX;
			if (count != 0 && lo <= hi && lo < count) begin
				top       = (hi > count - 1) ? int'(count - 1) : int'(hi);
				r.empty   = 1'b0;
				r.minimum = elems[lo];
				for (int i = int'(lo) + 1; i <= top; i++)
					if (elems[i] < r.minimum)
						r.minimum = elems[i];
			end
			pending_minima.push_back(r);
		endfunction

		function void check_result(logic [rmst_pkg::DATA_W-1:0] got_min, logic got_empty);
			min_result_t e;
			if (pending_minima.size() == 0) begin
				$display("%0t: unexpected result minimum %0d empty %0b", $time,
					$signed(got_min), got_empty);
				errors++;
				return;
			end
			e = pending_minima.pop_front();
			if (got_min !== e.minimum) begin
				$display("%0t: minimum expected %0d actual %0d", $time, e.minimum,
					$signed(got_min));
				errors++;
			end
			if (got_empty !== e.empty) begin
				$display("%0t: empty expected %0b actual %0b", $time, e.empty, got_empty);
				errors++;
			end
		endfunction
	endclass

	logic                             clk      = 1'b0;
	logic                             arst_n   = 1'b0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [rmst_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
	logic [0:0]                       s_tuser  = rmst_pkg::OP_LOAD;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [rmst_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic [0:0]                       m_tuser;
	logic                             psel     = 1'b0;
	logic                             penable  = 1'b0;
	logic                             pwrite   = 1'b0;
	logic [2:0]                       paddr    = '0;
	logic [31:0]                      pwdata   = '0;
	logic [31:0]                      prdata;
	logic                             pready;

	range_min_board board = new;
	bit             quiet = 1'b0;
	int             hold_request = 0;

	range_minimum_segment_tree_unit #(.MAX_ELEMENTS(MAX_COUNT)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			board.note_word(s_tuser[0], s_tdata[rmst_pkg::INDEX_LSB +: rmst_pkg::IDX_W],
				s_tdata[rmst_pkg::VALUE_LSB +: rmst_pkg::DATA_W],
				s_tdata[rmst_pkg::RLOW_LSB +: rmst_pkg::IDX_W],
				s_tdata[rmst_pkg::RHIGH_LSB +: rmst_pkg::IDX_W]);
		if (m_tvalid && m_tready)
			board.check_result(m_tdata, m_tuser[0]);
	end

	initial begin : result_sink
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_request > 0) begin
				stall        = hold_request;
				hold_request = 0;
			end else begin
				stall = quiet ? 0 : $urandom_range(0, MAX_IDLE);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	function automatic logic [rmst_pkg::DATA_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'($urandom_range(0, 15)) - 32'd8;
			default: return $urandom();
		endcase
	endfunction

	task automatic send_word(logic op, logic [rmst_pkg::IDX_W-1:0] idx,
		logic [rmst_pkg::DATA_W-1:0] val,
		logic [rmst_pkg::IDX_W-1:0] lo, logic [rmst_pkg::IDX_W-1:0] hi);
		int                              gap;
		logic [rmst_pkg::IN_TDATA_W-1:0] word;
		gap = quiet ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		word = '0;
		word[rmst_pkg::INDEX_LSB +: rmst_pkg::IDX_W] = idx;
		word[rmst_pkg::VALUE_LSB +: rmst_pkg::DATA_W] = val;
		word[rmst_pkg::RLOW_LSB +: rmst_pkg::IDX_W] = lo;
		word[rmst_pkg::RHIGH_LSB +: rmst_pkg::IDX_W] = hi;
		s_tdata  <= word;
		s_tuser  <= op;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_load(int idx, logic [rmst_pkg::DATA_W-1:0] val);
		send_word(rmst_pkg::OP_LOAD, rmst_pkg::IDX_W'(idx), val,
			rmst_pkg::IDX_W'($urandom()), rmst_pkg::IDX_W'($urandom()));
	endtask

	task automatic send_query(int lo, int hi);
		send_word(rmst_pkg::OP_QUERY, rmst_pkg::IDX_W'($urandom()), $urandom(),
			rmst_pkg::IDX_W'(lo), rmst_pkg::IDX_W'(hi));
	endtask

	// drop valid, wait out every pending result and the tail of the last tree walk
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.pending_minima.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(logic [rmst_pkg::CNT_W-1:0] v);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= COUNT_ADDR;
		pwdata  <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		board.set_count(v);
	endtask

	task automatic check_count(logic [31:0] want);
		psel    <= 1'b1;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		paddr   <= COUNT_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== want) begin
			$display("%0t: element_count expected %0d actual %0d", $time, want, prdata);
			board.errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// load every element in use, in shuffled order
	task automatic fill_all();
		int order [$];
		int j, t;
		for (int i = 0; i < int'(board.count); i++)
			order.push_back(i);
		for (int i = order.size() - 1; i > 0; i--) begin
			j        = $urandom_range(0, i);
			t        = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		foreach (order[k])
			send_load(order[k], pick_value());
	endtask

	task automatic directed_words();
		send_query(0, MAX_COUNT - 1);
		send_query(0, 0);
		send_query(MAX_COUNT - 1, MAX_COUNT - 1);
		send_load(0, 32'h8000_0000);
		send_query(0, MAX_COUNT - 1);
		send_load(MAX_COUNT - 1, 32'h7FFF_FFFF);
		send_query(MAX_COUNT - 1, MAX_COUNT - 1);
		send_query(512, 511);
		send_query(MAX_COUNT - 1, 0);
		send_load(511, 32'hFFFF_FFFF);
		send_load(512, 32'h0000_0000);
		send_query(511, 512);
		send_load(0, 32'h7FFF_FFFF);
		send_query(0, 1);
		send_load(1, 32'h7FFF_FFFF);
		send_query(0, 1);
		send_query(1, MAX_COUNT - 1);
	endtask

	task automatic random_words(int n_items);
		int n, lo, hi, t;
		n = board.count;
		repeat (n_items) begin
			if ($urandom_range(0, 9) < 4) begin
				if (n > 0 && $urandom_range(0, 6) != 0)
					send_load($urandom_range(0, n - 1), pick_value());
				else
					send_load($urandom_range(0, MAX_COUNT - 1), pick_value());
			end else begin
				lo = $urandom_range(0, MAX_COUNT - 1);
				hi = $urandom_range(0, MAX_COUNT - 1);
				if (n > 0) begin
					case ($urandom_range(0, 5))
						0: begin
							lo = $urandom_range(0, n - 1);
							hi = $urandom_range(0, n - 1);
							if (lo > hi) begin
								t  = lo;
								lo = hi;
								hi = t;
							end
						end
						1: begin
							lo = $urandom_range(1, MAX_COUNT - 1);
							hi = $urandom_range(0, lo - 1);
						end
						2: begin
							if (n < MAX_COUNT)
								lo = $urandom_range(n, MAX_COUNT - 1);
						end
						3: begin
							lo = $urandom_range(0, n - 1);
							hi = $urandom_range(n - 1, MAX_COUNT - 1);
						end
						5: begin
							lo = $urandom_range(0, n - 1);
							hi = lo;
						end
						default: begin
						end
					endcase
				end
				send_query(lo, hi);
			end
		end
	endtask

	initial begin : stimulus
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_count(32'(rmst_pkg::COUNT_RESET));
		for (int p = 0; p < PHASES; p++) begin
			settle();
			write_count(rmst_pkg::CNT_W'(COUNT_PLAN[p]));
			quiet = (p == 2 || p == 6 || p == 7);
			fill_all();
			if (p == 0)
				directed_words();
			if (p == 6)
				hold_request = LONG_HOLD;
			random_words(p == 0 ? 30 : 16);
		end
		settle();
		if (board.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : watchdog
		#(12_000_000);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
